// ===== rtl/lik_pkg.sv =====
`default_nettype none
package lik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TAB_LEN = 24;
  localparam int DIV_STEPS = 15;
  localparam int SQRT_STEPS = 15;

  // configuration register indexes
  localparam logic [2:0] CFG_THIGH = 3'd0;
  localparam logic [2:0] CFG_SHANK = 3'd1;
  localparam logic [2:0] CFG_FOOT_FWD = 3'd2;
  localparam logic [2:0] CFG_NEUTRAL_X = 3'd3;
  localparam logic [2:0] CFG_NEUTRAL_Y = 3'd4;
  localparam logic [2:0] CFG_SLEW = 3'd5;
  localparam logic [2:0] CFG_AMPLITUDE = 3'd6;
  localparam logic [2:0] CFG_TILT = 3'd7;

  localparam logic [14:0] THIGH_RST = 15'd1600;
  localparam logic [14:0] SHANK_RST = 15'd1600;
  localparam logic signed [15:0] FOOT_FWD_RST = 16'sd0;
  localparam logic signed [15:0] NEUTRAL_X_RST = 16'sd0;
  localparam logic signed [15:0] NEUTRAL_Y_RST = -16'sd3000;
  localparam logic [14:0] SLEW_RST = 15'd16;
  localparam logic [14:0] AMPLITUDE_RST = 15'd480;
  localparam logic [14:0] TILT_RST = 15'd2145;

  // datapath operations
  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_CLAMP = 4'd2;
  localparam logic [3:0] OP_DX = 4'd3;
  localparam logic [3:0] OP_DIV_INIT = 4'd4;
  localparam logic [3:0] OP_DIV_STEP = 4'd5;
  localparam logic [3:0] OP_COS = 4'd6;
  localparam logic [3:0] OP_SQRT_INIT = 4'd7;
  localparam logic [3:0] OP_SQRT_STEP = 4'd8;
  localparam logic [3:0] OP_CORD_LD = 4'd9;
  localparam logic [3:0] OP_NORM = 4'd10;
  localparam logic [3:0] OP_QUAD = 4'd11;
  localparam logic [3:0] OP_ROT = 4'd12;
  localparam logic [3:0] OP_SAVE = 4'd13;

  // multiplier operand pairs
  localparam logic [2:0] MS_DXDX = 3'd0;
  localparam logic [2:0] MS_YY = 3'd1;
  localparam logic [2:0] MS_L1L1 = 3'd2;
  localparam logic [2:0] MS_L2L2 = 3'd3;
  localparam logic [2:0] MS_L1L2 = 3'd4;
  localparam logic [2:0] MS_CC = 3'd5;
  localparam logic [2:0] MS_L2S = 3'd6;
  localparam logic [2:0] MS_L2C = 3'd7;

  // product accumulate modes
  localparam logic [2:0] AC_NONE = 3'd0;
  localparam logic [2:0] AC_LD = 3'd1;
  localparam logic [2:0] AC_ADD = 3'd2;
  localparam logic [2:0] AC_SUB = 3'd3;
  localparam logic [2:0] AC_DEN = 3'd4;
  localparam logic [2:0] AC_Y3 = 3'd5;
  localparam logic [2:0] AC_X3 = 3'd6;

  // atan2 jobs
  localparam logic [1:0] JOB_KNEE = 2'd0;
  localparam logic [1:0] JOB_FOOT = 2'd1;
  localparam logic [1:0] JOB_LINK = 2'd2;

  typedef struct packed {
    logic [14:0] thigh_length;
    logic [14:0] shank_length;
    logic signed [15:0] foot_forward_offset;
    logic signed [15:0] neutral_foot_x;
    logic signed [15:0] neutral_foot_y;
    logic [14:0] slew_step;
    logic [14:0] sway_amplitude;
    logic [14:0] tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] msel;
    logic [2:0] amode;
    logic [1:0] job;
  } dp_cmd_t;

  typedef struct packed {
    logic halted;
    logic zero;
    logic norm_need;
    logic div_last;
    logic sqrt_last;
    logic rot_last;
  } dp_status_t;

  function automatic logic signed [31:0] q24_round(input logic signed [31:0] v, input int ab);
    int sh;
    logic signed [31:0] r;
    sh = 24 - ab;
    if (sh <= 0) begin
      r = v;
    end else begin
      r = (v + (32'sd1 <<< (sh - 1))) >>> sh;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] atan_const(input logic [4:0] idx, input int ab);
    logic signed [31:0] v;
    case (idx)
      5'd0: v = 32'sd13176795;
      5'd1: v = 32'sd7778716;
      5'd2: v = 32'sd4110060;
      5'd3: v = 32'sd2086331;
      5'd4: v = 32'sd1047214;
      5'd5: v = 32'sd524117;
      5'd6: v = 32'sd262123;
      5'd7: v = 32'sd131069;
      5'd8: v = 32'sd65536;
      5'd9: v = 32'sd32768;
      5'd10: v = 32'sd16384;
      5'd11: v = 32'sd8192;
      5'd12: v = 32'sd4096;
      5'd13: v = 32'sd2048;
      5'd14: v = 32'sd1024;
      5'd15: v = 32'sd512;
      5'd16: v = 32'sd256;
      5'd17: v = 32'sd128;
      5'd18: v = 32'sd64;
      5'd19: v = 32'sd32;
      5'd20: v = 32'sd16;
      5'd21: v = 32'sd8;
      5'd22: v = 32'sd4;
      5'd23: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return q24_round(v, ab);
  endfunction

  function automatic logic signed [31:0] pi_const(input int ab);
    return q24_round(32'sd52707179, ab);
  endfunction

  function automatic logic signed [31:0] half_pi_const(input int ab);
    return q24_round(32'sd26353589, ab);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/slewed_two_link_leg_ik_unit.sv =====
`default_nettype none
// channel  dir  signals                          payload
// in       in   in_tvalid/in_tready/in_tdata     target_offset, body_pitch, body_roll
// out      out  out_tvalid/out_tready/out_tdata  hip_pitch_angle, knee_angle (+tuser)
// cfg      in   cfg_wr_en/cfg_index/cfg_wdata    eight link and limit registers
//
// one item at a time. The time from transfer in to out_tvalid is set by the
// one-bit-per-cycle normalize shifts and CORDIC_STEPS
// rotations of the three atan2 passes, plus the 15-step divide and square root loops.
// a halted tick goes from the clamp state straight to the done state. reset is synchronous,
// active low. the result register lets the next item start while the last waits on
// out_tready; a finished item holds until that register is free.
module slewed_two_link_leg_ik_unit #(
  parameter int CORDIC_STEPS = lik_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS = lik_pkg::ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // target_offset, body_pitch, body_roll
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // hip_pitch_angle, knee_angle
  output logic             out_tuser,  // servos_halted
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  lik_pkg::cfg_t      cfg_r;
  lik_pkg::dp_cmd_t   cmd;
  lik_pkg::dp_status_t status;
  logic               out_free;
  logic               done;
  logic signed [15:0] hip_pitch_angle;
  logic signed [15:0] knee_angle;
  logic               servos_halted;
  logic               out_tvalid_r;
  logic [31:0]        out_tdata_r;
  logic               out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thigh_length <= lik_pkg::THIGH_RST;
      cfg_r.shank_length <= lik_pkg::SHANK_RST;
      cfg_r.foot_forward_offset <= lik_pkg::FOOT_FWD_RST;
      cfg_r.neutral_foot_x <= lik_pkg::NEUTRAL_X_RST;
      cfg_r.neutral_foot_y <= lik_pkg::NEUTRAL_Y_RST;
      cfg_r.slew_step <= lik_pkg::SLEW_RST;
      cfg_r.sway_amplitude <= lik_pkg::AMPLITUDE_RST;
      cfg_r.tilt_limit <= lik_pkg::TILT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lik_pkg::CFG_THIGH: cfg_r.thigh_length <= cfg_wdata[14:0];
        lik_pkg::CFG_SHANK: cfg_r.shank_length <= cfg_wdata[14:0];
        lik_pkg::CFG_FOOT_FWD: cfg_r.foot_forward_offset <= cfg_wdata;
        lik_pkg::CFG_NEUTRAL_X: cfg_r.neutral_foot_x <= cfg_wdata;
        lik_pkg::CFG_NEUTRAL_Y: cfg_r.neutral_foot_y <= cfg_wdata;
        lik_pkg::CFG_SLEW: cfg_r.slew_step <= cfg_wdata[14:0];
        lik_pkg::CFG_AMPLITUDE: cfg_r.sway_amplitude <= cfg_wdata[14:0];
        lik_pkg::CFG_TILT: cfg_r.tilt_limit <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  lik_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_tready),
    .done     (done),
    .cmd      (cmd)
  );

  lik_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_target       (in_tdata[15:0]),
    .in_pitch        (in_tdata[31:16]),
    .in_roll         (in_tdata[47:32]),
    .cmd             (cmd),
    .status          (status),
    .hip_pitch_angle (hip_pitch_angle),
    .knee_angle      (knee_angle),
    .servos_halted   (servos_halted)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_tdata_r <= {knee_angle, hip_pitch_angle};
      out_tuser_r <= servos_halted;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule
`default_nettype wire

// ===== rtl/lik_dp.sv =====
`default_nettype none
module lik_dp #(
  parameter int CORDIC_STEPS = lik_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS = lik_pkg::ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lik_pkg::cfg_t      cfg,
  input  wire logic signed [15:0] in_target,
  input  wire logic signed [15:0] in_pitch,
  input  wire logic signed [15:0] in_roll,
  input  wire lik_pkg::dp_cmd_t   cmd,
  output lik_pkg::dp_status_t     status,
  output logic signed [15:0]      hip_pitch_angle,
  output logic signed [15:0]      knee_angle,
  output logic                    servos_halted
);

  localparam int CW = 36;
  localparam int ZW = ANGLE_BITS + 6;
  localparam int NW = 38;
  localparam int ROT_N = (CORDIC_STEPS < lik_pkg::TAB_LEN) ? CORDIC_STEPS : lik_pkg::TAB_LEN;
  localparam logic [4:0] ROT_LAST = 5'(ROT_N - 1);
  localparam logic [4:0] DIV_LAST = 5'(lik_pkg::DIV_STEPS - 1);
  localparam logic [4:0] SQRT_LAST = 5'(lik_pkg::SQRT_STEPS - 1);
  localparam int SH = ANGLE_BITS - 12;
  localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;
  localparam logic signed [ZW-1:0] RND_Z = ZW'(RND);
  localparam logic signed [ZW-1:0] PI_Z = ZW'(lik_pkg::pi_const(ANGLE_BITS));
  localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(lik_pkg::half_pi_const(ANGLE_BITS));
  localparam logic signed [CW-1:0] LIM = CW'(1) <<< 30;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  logic               halted_r;
  logic signed [15:0] offset_r;
  logic signed [17:0] off_sum_r;
  logic signed [17:0] dx_r;
  logic signed [35:0] prod_r;
  logic signed [NW-1:0] num_r;
  logic [31:0]        den_r;
  logic signed [31:0] x3_r;
  logic signed [31:0] y3_r;
  logic [31:0]        rem_r;
  logic [14:0]        quo_r;
  logic               sat_r;
  logic               neg_r;
  logic signed [15:0] c_r;
  logic [28:0]        sqv_r;
  logic [29:0]        root_r;
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic signed [ZW-1:0] cz_r;
  logic signed [ZW-1:0] knee_r;
  logic signed [ZW-1:0] hip_r;
  logic [4:0]         cnt_r;

  logic signed [17:0] ma, mb;
  logic signed [16:0] p17, r17, ap, ar, tilt_s, err, step_s, errc;
  logic               halt_now;
  logic signed [17:0] amp_s;
  logic signed [17:0] off_c;
  logic [NW-1:0]      mag;
  logic [32:0]        dshift;
  logic               dge;
  logic [15:0]        qinc;
  logic [29:0]        sbit;
  logic [29:0]        rb;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  logic               zero;
  logic signed [ZW-1:0] hip_rnd, knee_rnd;

  always_comb begin
    case (cmd.msel)
      lik_pkg::MS_DXDX: begin ma = dx_r; mb = dx_r; end
      lik_pkg::MS_YY: begin ma = 18'(cfg.neutral_foot_y); mb = 18'(cfg.neutral_foot_y); end
      lik_pkg::MS_L1L1: begin ma = {3'b0, cfg.thigh_length}; mb = {3'b0, cfg.thigh_length}; end
      lik_pkg::MS_L2L2: begin ma = {3'b0, cfg.shank_length}; mb = {3'b0, cfg.shank_length}; end
      lik_pkg::MS_L1L2: begin ma = {3'b0, cfg.thigh_length}; mb = {3'b0, cfg.shank_length}; end
      lik_pkg::MS_CC: begin ma = 18'(c_r); mb = 18'(c_r); end
      lik_pkg::MS_L2S: begin ma = {3'b0, cfg.shank_length}; mb = {3'b0, root_r[14:0]}; end
      lik_pkg::MS_L2C: begin ma = {3'b0, cfg.shank_length}; mb = 18'(c_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    p17 = 17'(in_pitch);
    r17 = 17'(in_roll);
    ap = (p17 < 0) ? -p17 : p17;
    ar = (r17 < 0) ? -r17 : r17;
    tilt_s = $signed({2'b0, cfg.tilt_limit});
    halt_now = halted_r || (ap > tilt_s) || (ar > tilt_s);
    step_s = $signed({2'b0, cfg.slew_step});
    err = 17'(in_target) - 17'(offset_r);
    if (err > step_s) begin
      errc = step_s;
    end else if (err < -step_s) begin
      errc = -step_s;
    end else begin
      errc = err;
    end
    amp_s = $signed({3'b0, cfg.sway_amplitude});
    if (off_sum_r > amp_s) begin
      off_c = amp_s;
    end else if (off_sum_r < -amp_s) begin
      off_c = -amp_s;
    end else begin
      off_c = off_sum_r;
    end
    mag = (num_r < 0) ? NW'(-num_r) : NW'(num_r);
    dshift = {rem_r, 1'b0};
    dge = dshift >= {1'b0, den_r};
    qinc = {1'b0, quo_r} + 16'd1;
    // bit walks down from 2^28 by factors of four
    sbit = 30'(1) << (5'd28 - {cnt_r[3:0], 1'b0});
    rb = root_r + sbit;
    xs = cx_r >>> cnt_r;
    ys = cy_r >>> cnt_r;
    ang = ZW'(lik_pkg::atan_const(cnt_r, ANGLE_BITS));
    zero = (cx_r == '0) && (cy_r == '0);
    hip_rnd = (hip_r + RND_Z) >>> SH;
    knee_rnd = (knee_r + RND_Z) >>> SH;
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (cmd.amode)
      lik_pkg::AC_LD: num_r <= NW'(prod_r);
      lik_pkg::AC_ADD: num_r <= num_r + NW'(prod_r);
      lik_pkg::AC_SUB: num_r <= num_r - NW'(prod_r);
      lik_pkg::AC_DEN: den_r <= {prod_r[30:0], 1'b0};
      lik_pkg::AC_Y3: y3_r <= prod_r[31:0];
      lik_pkg::AC_X3: x3_r <= $signed({3'b0, cfg.thigh_length, 14'b0}) + prod_r[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      offset_r <= '0;
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        lik_pkg::OP_LOAD: begin
          halted_r <= halt_now;
          off_sum_r <= 18'(offset_r) + 18'(errc);
        end
        lik_pkg::OP_CLAMP: offset_r <= off_c[15:0];
        lik_pkg::OP_DX: dx_r <= 18'(cfg.neutral_foot_x) - 18'(offset_r)
                                - 18'(cfg.foot_forward_offset);
        lik_pkg::OP_DIV_INIT: begin
          sat_r <= mag >= NW'(den_r);
          neg_r <= num_r < 0;
          rem_r <= mag[31:0];
          quo_r <= '0;
          cnt_r <= '0;
        end
        lik_pkg::OP_DIV_STEP: begin
          rem_r <= dge ? 32'(dshift - {1'b0, den_r}) : dshift[31:0];
          quo_r <= {quo_r[13:0], dge};
          cnt_r <= cnt_r + 5'd1;
        end
        lik_pkg::OP_COS: begin
          if (sat_r) begin
            c_r <= neg_r ? -ONE_Q14 : ONE_Q14;
          end else begin
            c_r <= neg_r ? -$signed({1'b0, qinc[15:1]}) : $signed({1'b0, qinc[15:1]});
          end
        end
        lik_pkg::OP_SQRT_INIT: begin
          sqv_r <= 29'(36'sh10000000 - prod_r);
          root_r <= '0;
          cnt_r <= '0;
        end
        lik_pkg::OP_SQRT_STEP: begin
          if ({1'b0, sqv_r} >= rb) begin
            sqv_r <= 29'({1'b0, sqv_r} - rb);
            root_r <= (root_r >> 1) + sbit;
          end else begin
            root_r <= root_r >> 1;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        lik_pkg::OP_CORD_LD: begin
          cz_r <= '0;
          case (cmd.job)
            lik_pkg::JOB_KNEE: begin
              cx_r <= CW'(c_r);
              cy_r <= CW'($signed({1'b0, root_r[14:0]}));
            end
            lik_pkg::JOB_FOOT: begin
              cx_r <= CW'(dx_r);
              cy_r <= CW'(cfg.neutral_foot_y);
            end
            default: begin
              cx_r <= CW'(x3_r);
              cy_r <= CW'(y3_r);
            end
          endcase
        end
        lik_pkg::OP_NORM: begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
        lik_pkg::OP_QUAD: begin
          // left half-plane: rotate by pi first
          if (cx_r < 0) begin
            cz_r <= (cy_r >= 0) ? PI_Z : -PI_Z;
            cx_r <= -cx_r;
            cy_r <= -cy_r;
          end
          cnt_r <= '0;
        end
        lik_pkg::OP_ROT: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + ang;
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - ang;
          end
          cnt_r <= cnt_r + 5'd1;
        end
        lik_pkg::OP_SAVE: begin
          case (cmd.job)
            lik_pkg::JOB_KNEE: knee_r <= cz_r;
            lik_pkg::JOB_FOOT: hip_r <= cz_r;
            default: hip_r <= hip_r - cz_r + HALF_PI_Z;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.halted = halted_r;
    status.zero = zero;
    status.norm_need = !zero && (cx_r < LIM) && (cx_r > -LIM) && (cy_r < LIM) && (cy_r > -LIM);
    status.div_last = cnt_r == DIV_LAST;
    status.sqrt_last = cnt_r == SQRT_LAST;
    status.rot_last = cnt_r == ROT_LAST;
    servos_halted = halted_r;
    if (halted_r) begin
      hip_pitch_angle = '0;
      knee_angle = '0;
    end else begin
      if (hip_rnd > ZW'(32767)) begin
        hip_pitch_angle = 16'sh7fff;
      end else if (hip_rnd < -ZW'(32768)) begin
        hip_pitch_angle = 16'sh8000;
      end else begin
        hip_pitch_angle = hip_rnd[15:0];
      end
      if (knee_rnd > ZW'(32767)) begin
        knee_angle = 16'sh7fff;
      end else if (knee_rnd < -ZW'(32768)) begin
        knee_angle = 16'sh8000;
      end else begin
        knee_angle = knee_rnd[15:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lik_ctrl.sv =====
`default_nettype none
module lik_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                out_free,
  input  wire lik_pkg::dp_status_t status,
  output logic                     in_ready,
  output logic                     done,
  output lik_pkg::dp_cmd_t         cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLAMP = 5'd1;
  localparam logic [4:0] S_DX = 5'd2;
  localparam logic [4:0] S_M0 = 5'd3;
  localparam logic [4:0] S_M1 = 5'd4;
  localparam logic [4:0] S_M2 = 5'd5;
  localparam logic [4:0] S_M3 = 5'd6;
  localparam logic [4:0] S_M4 = 5'd7;
  localparam logic [4:0] S_M5 = 5'd8;
  localparam logic [4:0] S_DIVI = 5'd9;
  localparam logic [4:0] S_DIV = 5'd10;
  localparam logic [4:0] S_COS = 5'd11;
  localparam logic [4:0] S_M6 = 5'd12;
  localparam logic [4:0] S_SQI = 5'd13;
  localparam logic [4:0] S_SQ = 5'd14;
  localparam logic [4:0] S_M7 = 5'd15;
  localparam logic [4:0] S_M8 = 5'd16;
  localparam logic [4:0] S_M9 = 5'd17;
  localparam logic [4:0] S_CLD = 5'd18;
  localparam logic [4:0] S_NORM = 5'd19;
  localparam logic [4:0] S_QUAD = 5'd20;
  localparam logic [4:0] S_ROT = 5'd21;
  localparam logic [4:0] S_SAVE = 5'd22;
  localparam logic [4:0] S_DONE = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic [1:0] job_r, job_nxt;

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    cmd.op = lik_pkg::OP_NOP;
    cmd.msel = lik_pkg::MS_DXDX;
    cmd.amode = lik_pkg::AC_NONE;
    cmd.job = job_r;
    in_ready = 1'b0;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = lik_pkg::OP_LOAD;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (status.halted) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = lik_pkg::OP_CLAMP;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        cmd.op = lik_pkg::OP_DX;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.msel = lik_pkg::MS_DXDX;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.msel = lik_pkg::MS_YY;
        cmd.amode = lik_pkg::AC_LD;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.msel = lik_pkg::MS_L1L1;
        cmd.amode = lik_pkg::AC_ADD;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.msel = lik_pkg::MS_L2L2;
        cmd.amode = lik_pkg::AC_SUB;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.msel = lik_pkg::MS_L1L2;
        cmd.amode = lik_pkg::AC_SUB;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.amode = lik_pkg::AC_DEN;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op = lik_pkg::OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = lik_pkg::OP_DIV_STEP;
        if (status.div_last) state_nxt = S_COS;
      end
      S_COS: begin
        cmd.op = lik_pkg::OP_COS;
        state_nxt = S_M6;
      end
      S_M6: begin
        cmd.msel = lik_pkg::MS_CC;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op = lik_pkg::OP_SQRT_INIT;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = lik_pkg::OP_SQRT_STEP;
        if (status.sqrt_last) state_nxt = S_M7;
      end
      S_M7: begin
        cmd.msel = lik_pkg::MS_L2S;
        state_nxt = S_M8;
      end
      S_M8: begin
        cmd.msel = lik_pkg::MS_L2C;
        cmd.amode = lik_pkg::AC_Y3;
        state_nxt = S_M9;
      end
      S_M9: begin
        cmd.amode = lik_pkg::AC_X3;
        job_nxt = lik_pkg::JOB_KNEE;
        state_nxt = S_CLD;
      end
      S_CLD: begin
        cmd.op = lik_pkg::OP_CORD_LD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // zero vector keeps angle zero
        if (status.zero) begin
          state_nxt = S_SAVE;
        end else if (status.norm_need) begin
          cmd.op = lik_pkg::OP_NORM;
        end else begin
          state_nxt = S_QUAD;
        end
      end
      S_QUAD: begin
        cmd.op = lik_pkg::OP_QUAD;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op = lik_pkg::OP_ROT;
        if (status.rot_last) state_nxt = S_SAVE;
      end
      S_SAVE: begin
        cmd.op = lik_pkg::OP_SAVE;
        if (job_r == lik_pkg::JOB_LINK) begin
          state_nxt = S_DONE;
        end else begin
          job_nxt = job_r + 2'd1;
          state_nxt = S_CLD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r <= lik_pkg::JOB_KNEE;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire
